### rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants of the linear probe hash table
// Table geometry, field widths, slot layout and the sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    // Table geometry (TABLE_SIZE is a power of two, so the home slot is a mask)
    localparam int TABLE_SIZE = 16;
    localparam int KEY_BYTES  = 8;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int BSEL_W     = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    // Field widths
    localparam int KEY_W  = 64;
    localparam int LEN_W  = 4;
    localparam int VAL_W  = 32;
    localparam int HASH_W = 32;

    // Times33 step: h * 33 = (h << 5) + h
    localparam int HASH_SHIFT = 5;

    // Request codes
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_SET    = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
        logic [VAL_W-1:0] value;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_READ,
        S_CMP
    } t_state;

endpackage

`default_nettype wire

### rtl/times33_linear_probe_hash_table_core.sv
// ----------------------------------------------------------------------------
// times33_linear_probe_hash_table_core: Times33 open-addressing key/value map
// Maps keys of up to eight bytes to 32-bit values with linear probing.
// ----------------------------------------------------------------------------
// Sequence: a hash over the key_len bytes (key_len after saturation), then a RAM
//   read and a compare for each slot probed, then the result strobe; the probe
//   walks at most the whole table.
// Flow: one item at a time; busy stays high until the walk ends, and the
//   next item may start in the cycle of the result strobe. The receiver cannot
//   stall, so results never hold the block up.
// Reset: synchronous, active low; clears the sequencer, the slot valid bits and
//   the strobe. Slot contents are not cleared, but an invalid slot never matches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module times33_linear_probe_hash_table_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    output logic                            o_busy,
    input  wire logic                       i_req_type,
    input  wire logic [lpht_pkg::KEY_W-1:0] i_key_bytes,
    input  wire logic [lpht_pkg::LEN_W-1:0] i_key_len,
    input  wire logic signed [lpht_pkg::VAL_W-1:0] i_new_value,
    output logic                            o_done,
    output logic                            o_hit,
    output logic signed [lpht_pkg::VAL_W-1:0] o_read_value,
    output logic                            o_full_res
);

    // ------------------------------------------------------------------
    // Sequencer state and latched request
    // ------------------------------------------------------------------
    lpht_pkg::t_state                r_state;
    lpht_pkg::t_state                n_state;

    logic                            r_req_type;
    logic [lpht_pkg::KEY_W-1:0]      r_key;
    logic [lpht_pkg::LEN_W-1:0]      r_len;
    logic [lpht_pkg::VAL_W-1:0]      r_value;
    logic [lpht_pkg::IDX_W-1:0]      r_idx;
    logic [lpht_pkg::IDX_W-1:0]      n_idx;
    logic [lpht_pkg::IDX_W-1:0]      r_cnt;
    logic [lpht_pkg::IDX_W-1:0]      n_cnt;
    logic [lpht_pkg::TABLE_SIZE-1:0] r_valid;

    // Result registers
    logic                            r_done;
    logic                            r_hit;
    logic [lpht_pkg::VAL_W-1:0]      r_read_value;
    logic                            r_full;

    // Request conditioning
    logic [lpht_pkg::LEN_W-1:0]      len_sat;
    logic [lpht_pkg::KEY_W-1:0]      key_masked;

    // Hash unit
    logic                            hash_start;
    logic                            hash_done;
    logic [lpht_pkg::HASH_W-1:0]     hash_val;

    // Slot RAM
    logic                            ram_re;
    logic                            ram_we;
    logic [lpht_pkg::SLOT_W-1:0]     ram_rdata;
    lpht_pkg::t_slot                 slot_rd;
    lpht_pkg::t_slot                 slot_wr;

    // Probe outcome
    logic                            slot_empty;
    logic                            slot_match;
    logic                            last_probe;
    logic                            finish;

    // ------------------------------------------------------------------
    // Saturate the length and zero the bytes beyond it, so that stored keys
    // compare by content alone.
    // ------------------------------------------------------------------
    always_comb begin
        if (i_key_len > lpht_pkg::LEN_W'(lpht_pkg::KEY_BYTES)) begin
            len_sat = lpht_pkg::LEN_W'(lpht_pkg::KEY_BYTES);
        end else begin
            len_sat = i_key_len;
        end
        key_masked = '0;
        for (int b = 0; b < lpht_pkg::KEY_BYTES; b++) begin
            if (lpht_pkg::LEN_W'(b) < len_sat) begin
                key_masked[b*8 +: 8] = i_key_bytes[b*8 +: 8];
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared hash unit: one byte per cycle
    // ------------------------------------------------------------------
    lpht_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (r_key),
        .i_len   (r_len),
        .o_done  (hash_done),
        .o_hash  (hash_val)
    );

    // ------------------------------------------------------------------
    // Slot store: key, length and value of each slot in one RAM word
    // ------------------------------------------------------------------
    assign slot_wr.key   = r_key;
    assign slot_wr.len   = r_len;
    assign slot_wr.value = r_value;

    lpht_ram #(
        .WIDTH (lpht_pkg::SLOT_W),
        .DEPTH (lpht_pkg::TABLE_SIZE)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (slot_wr),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign slot_rd = lpht_pkg::t_slot'(ram_rdata);

    // Compare the slot read in the previous cycle against the request.
    assign slot_empty = !r_valid[r_idx];
    assign slot_match = !slot_empty && (slot_rd.len == r_len) && (slot_rd.key == r_key);
    assign last_probe = (r_cnt == lpht_pkg::IDX_W'(lpht_pkg::TABLE_SIZE - 1));

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            lpht_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = lpht_pkg::S_HASH;
                end
            end
            lpht_pkg::S_HASH: begin
                if (hash_done) begin
                    n_state = lpht_pkg::S_READ;
                end
            end
            lpht_pkg::S_READ: begin
                n_state = lpht_pkg::S_CMP;
            end
            lpht_pkg::S_CMP: begin
                if (slot_empty || slot_match || last_probe) begin
                    n_state = lpht_pkg::S_IDLE;
                end else begin
                    n_state = lpht_pkg::S_READ;
                end
            end
            default: begin
                n_state = lpht_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------
    always_comb begin
        hash_start = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        finish     = 1'b0;
        case (r_state)
            lpht_pkg::S_IDLE: begin
                hash_start = i_start;
            end
            lpht_pkg::S_HASH: begin
                hash_start = 1'b0;
            end
            lpht_pkg::S_READ: begin
                ram_re = 1'b1;
            end
            lpht_pkg::S_CMP: begin
                // Fill an empty slot or update the matching one on set.
                ram_we = (r_req_type == lpht_pkg::REQ_SET) && (slot_empty || slot_match);
                finish = slot_empty || slot_match || last_probe;
            end
            default: begin
                finish = 1'b0;
            end
        endcase
    end

    // Probe pointer: home slot from the hash, then advance with wrap-around.
    always_comb begin
        n_idx = r_idx;
        n_cnt = r_cnt;
        if (r_state == lpht_pkg::S_HASH && hash_done) begin
            n_idx = hash_val[lpht_pkg::IDX_W-1:0];
            n_cnt = '0;
        end else if (r_state == lpht_pkg::S_CMP && !finish) begin
            if (r_idx == lpht_pkg::IDX_W'(lpht_pkg::TABLE_SIZE - 1)) begin
                n_idx = '0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
            n_cnt = r_cnt + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpht_pkg::S_IDLE;
            r_valid <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= finish;
            if (ram_we && slot_empty) begin
                r_valid[r_idx] <= 1'b1;
            end
        end

        // Latch the item on accept.
        if (r_state == lpht_pkg::S_IDLE && i_start) begin
            r_req_type <= i_req_type;
            r_key      <= key_masked;
            r_len      <= len_sat;
            r_value    <= i_new_value;
        end

        r_idx <= n_idx;
        r_cnt <= n_cnt;

        // Hold the result for the strobe cycle.
        if (finish) begin
            r_hit  <= slot_match;
            r_full <= (r_req_type == lpht_pkg::REQ_SET) && !slot_empty && !slot_match;
            if (r_req_type == lpht_pkg::REQ_LOOKUP && slot_match) begin
                r_read_value <= slot_rd.value;
            end else begin
                r_read_value <= '0;
            end
        end
    end

    assign o_busy       = (r_state != lpht_pkg::S_IDLE);
    assign o_done       = r_done;
    assign o_hit        = r_hit;
    assign o_read_value = r_read_value;
    assign o_full_res   = r_full;

endmodule

`default_nettype wire

### rtl/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/lpht_hash.sv
// ----------------------------------------------------------------------------
// lpht_hash: iterative Times33 hash unit
// Folds one key byte per cycle into a 32-bit hash; done when all bytes are in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpht_hash (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [lpht_pkg::KEY_W-1:0]  i_key,
    input  wire logic [lpht_pkg::LEN_W-1:0]  i_len,
    output logic                             o_done,
    output logic      [lpht_pkg::HASH_W-1:0] o_hash
);

    logic                          r_busy;
    logic                          n_busy;
    logic [lpht_pkg::HASH_W-1:0]   r_h;
    logic [lpht_pkg::HASH_W-1:0]   n_h;
    logic [lpht_pkg::LEN_W-1:0]    r_pos;
    logic [lpht_pkg::LEN_W-1:0]    n_pos;
    logic [lpht_pkg::KEY_BYTES-1:0][7:0] key_vec;
    logic [7:0]                    cur_byte;
    logic                          at_end;

    assign key_vec  = i_key[lpht_pkg::KEY_BYTES*8-1:0];
    assign cur_byte = key_vec[r_pos[lpht_pkg::BSEL_W-1:0]];
    assign at_end   = (r_pos == i_len);

    always_comb begin
        n_busy = r_busy;
        n_h    = r_h;
        n_pos  = r_pos;
        if (i_start) begin
            n_busy = 1'b1;
            n_h    = '0;
            n_pos  = '0;
        end else if (r_busy) begin
            if (at_end) begin
                n_busy = 1'b0;
            end else begin
                // h = h * 33 + byte
                n_h   = (r_h << lpht_pkg::HASH_SHIFT) + r_h
                        + {{(lpht_pkg::HASH_W-8){1'b0}}, cur_byte};
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_h   <= n_h;
        r_pos <= n_pos;
    end

    assign o_done = r_busy && at_end;
    assign o_hash = r_h;

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Times33 linear probe hash table
// Drives lookup and set commands through the start/busy handshake, predicts
// each answer with a behavioral map model and checks every done strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import lpht_pkg::*;

    // Worst single command: the accept, up to eight hash steps, a read and a compare
    // per slot over the whole table, then the strobe. Drain a little past that.
    localparam int DRAIN_CYCLES = 1 + KEY_BYTES + 2 * TABLE_SIZE + 8;
    // Give the slowest correct run ample room.
    localparam longint LIMIT_NS = 64'd5_000_000;
    localparam int POOL_SIZE    = 24;
    localparam int RANDOM_ITEMS = 1050;

    typedef struct {
        logic              hit;
        logic [VAL_W-1:0]  value;
        logic              full;
    } answer_t;

    // ------------------------------------------------------------------------
    // Map model and answer checker
    // ------------------------------------------------------------------------
    class map_scoreboard;
        bit               slot_used [TABLE_SIZE];
        logic [KEY_W-1:0] slot_key  [TABLE_SIZE];
        logic [LEN_W-1:0] slot_len  [TABLE_SIZE];
        logic [VAL_W-1:0] slot_val  [TABLE_SIZE];
        answer_t          expected_q[$];
        int               errors;
        int               n_lookup, n_lookup_hit, n_set, n_update, n_full;
        int               occupancy, longest_walk;

        function new();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            errors       = 0;
            n_lookup     = 0;
            n_lookup_hit = 0;
            n_set        = 0;
            n_update     = 0;
            n_full       = 0;
            occupancy    = 0;
            longest_walk = 0;
        endfunction

        static function logic [KEY_W-1:0] key_mask(int unsigned len);
            logic [KEY_W-1:0] m;
            m = '0;
            for (int unsigned i = 0; i < len; i++) m[8*i +: 8] = 8'hFF;
            return m;
        endfunction

        static function logic [HASH_W-1:0] times33_of(logic [KEY_W-1:0] key,
                                                      int unsigned len);
            logic [HASH_W-1:0] h;
            h = '0;
            for (int unsigned i = 0; i < len; i++)
                h = (h << HASH_SHIFT) + h + HASH_W'(key[8*i +: 8]);
            return h;
        endfunction

        // Apply one accepted command to the model and queue its answer.
        function void note_request(logic req, logic [KEY_W-1:0] key_in,
                                   logic [LEN_W-1:0] len_in, logic [VAL_W-1:0] value);
            int unsigned      len;
            int unsigned      idx;
            int unsigned      n;
            logic [KEY_W-1:0] key;
            answer_t          ans;
            bit               stop;
            len      = (len_in > KEY_BYTES) ? KEY_BYTES : len_in;
            key      = key_in & key_mask(len);
            idx      = times33_of(key, len) % TABLE_SIZE;
            ans.hit   = 1'b0;
            ans.value = '0;
            ans.full  = 1'b0;
            stop     = 1'b0;
            n        = 0;
            while (n < TABLE_SIZE && !stop) begin
                if (!slot_used[idx]) begin
                    if (req == REQ_SET) begin
                        slot_used[idx] = 1'b1;
                        slot_key[idx]  = key;
                        slot_len[idx]  = LEN_W'(len);
                        slot_val[idx]  = value;
                        occupancy++;
                    end
                    stop = 1'b1;
                end else if (slot_len[idx] == LEN_W'(len) && slot_key[idx] == key) begin
                    ans.hit = 1'b1;
                    if (req == REQ_SET) slot_val[idx] = value;
                    else                ans.value     = slot_val[idx];
                    stop = 1'b1;
                end else begin
                    idx = (idx + 1) % TABLE_SIZE;
                    n++;
                end
            end
            if (!stop && req == REQ_SET) ans.full = 1'b1;
            if (n + 1 > longest_walk) longest_walk = (n < TABLE_SIZE) ? n + 1 : n;
            if (req == REQ_SET) begin
                n_set++;
                if (ans.hit)  n_update++;
                if (ans.full) n_full++;
            end else begin
                n_lookup++;
                if (ans.hit) n_lookup_hit++;
            end
            expected_q.push_back(ans);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string what);
            errors++;
            if (errors <= 30) $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_answer(logic hit, logic [VAL_W-1:0] value, logic full);
            answer_t want;
            if (expected_q.size() == 0) begin
                report("done strobe with no command outstanding");
            end else begin
                want = expected_q.pop_front();
                if (hit !== want.hit)
                    report($sformatf("hit got %b want %b", hit, want.hit));
                if (value !== want.value)
                    report($sformatf("read_value got %h want %h", value, want.value));
                if (full !== want.full)
                    report($sformatf("full_res got %b want %b", full, want.full));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_start;
    logic                    o_busy;
    logic                    i_req_type;
    logic [KEY_W-1:0]        i_key_bytes;
    logic [LEN_W-1:0]        i_key_len;
    logic signed [VAL_W-1:0] i_new_value;
    logic                    o_done;
    logic                    o_hit;
    logic signed [VAL_W-1:0] o_read_value;
    logic                    o_full_res;

    times33_linear_probe_hash_table_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_req_type   (i_req_type),
        .i_key_bytes  (i_key_bytes),
        .i_key_len    (i_key_len),
        .i_new_value  (i_new_value),
        .o_done       (o_done),
        .o_hit        (o_hit),
        .o_read_value (o_read_value),
        .o_full_res   (o_full_res)
    );

    map_scoreboard    sb;
    logic [KEY_W-1:0] pool_key [POOL_SIZE];
    int unsigned      pool_len [POOL_SIZE];
    int               burst_left;
    int               n_random;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or drops a strobe.
    initial begin
        #(LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    // Answers come as one-cycle strobes; the receiver cannot hold them off,
    // so sample every edge. Values read here are the pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1)
            sb.check_answer(o_hit, o_read_value, o_full_res);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Present one command and hold it until the block takes it. Leave start
    // high on return; the caller lowers it only when it idles.
    task automatic send_item(input logic req, input logic [KEY_W-1:0] key,
                             input logic [LEN_W-1:0] len, input logic [VAL_W-1:0] value);
        i_start     <= 1'b1;
        i_req_type  <= req;
        i_key_bytes <= key;
        i_key_len   <= len;
        i_new_value <= value;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        sb.note_request(req, key, len, value);
    endtask

    // Idle the sender between commands. Short no-gap bursts keep back-to-back
    // starts (including the start in the strobe cycle) in every phase.
    task automatic idle_gap(input int idle_pct);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if ($urandom_range(15) == 0) burst_left = 8;
            while ($urandom_range(99) < idle_pct) begin
                // drop start and scramble the payload; it must be ignored
                i_start     <= 1'b0;
                i_req_type  <= 1'($urandom);
                i_key_bytes <= {$urandom, $urandom};
                i_key_len   <= 4'($urandom);
                i_new_value <= $urandom;
                @(posedge i_clk);
            end
        end
    endtask

    // Stray bits above the key length must not matter; fill them at random.
    function automatic logic [KEY_W-1:0] with_junk(logic [KEY_W-1:0] key, int unsigned len);
        logic [KEY_W-1:0] m;
        m = map_scoreboard::key_mask(len);
        return (key & m) | ({$urandom, $urandom} & ~m);
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Random commands. Most reuse a growing pool of keys so sets update and
    // lookups hit; the pool outgrows the table late in the run so the full
    // case and whole-table walks show up. The rest are fresh keys (noise).
    task automatic run_phase(input int items, input int idle_pct);
        int               k;
        int               limit;
        int unsigned      len;
        logic [LEN_W-1:0] len_drive;
        logic [KEY_W-1:0] key;
        logic             req;
        for (int i = 0; i < items; i++) begin
            limit = 4 + n_random / 35;
            if (limit > POOL_SIZE) limit = POOL_SIZE;
            if ($urandom_range(99) < 85) begin
                k         = $urandom_range(limit - 1);
                len       = pool_len[k];
                len_drive = LEN_W'(len);
                // saturated lengths name the same eight-byte key
                if (len == KEY_BYTES && $urandom_range(3) == 0)
                    len_drive = LEN_W'($urandom_range(15, KEY_BYTES + 1));
                key = with_junk(pool_key[k], len);
                req = ($urandom_range(1) == 0) ? REQ_LOOKUP : REQ_SET;
            end else begin
                len_drive = 4'($urandom);
                key       = {$urandom, $urandom};
                req       = ($urandom_range(7) == 0) ? REQ_SET : REQ_LOOKUP;
            end
            send_item(req, key, len_drive, pick_value());
            n_random++;
            idle_gap(idle_pct);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb          = new();
        burst_left  = 0;
        n_random    = 0;
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_req_type  <= REQ_LOOKUP;
        i_key_bytes <= '0;
        i_key_len   <= '0;
        i_new_value <= '0;

        // key pool: lengths from empty to full, content random
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_len[i] = $urandom_range(KEY_BYTES);
            pool_key[i] = {$urandom, $urandom} & map_scoreboard::key_mask(pool_len[i]);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed commands ----
        // miss on the empty table
        send_item(REQ_LOOKUP, 64'h61, 4'd1, 32'h1234_5678);
        // empty key: hash 0, any junk in key_bytes is ignored
        send_item(REQ_SET, 64'hDEAD_BEEF_0BAD_F00D, 4'd0, 32'h7FFF_FFFF);
        send_item(REQ_LOOKUP, 64'h0123_4567_89AB_CDEF, 4'd0, '0);
        // all-ones key; a length above eight saturates to eight
        send_item(REQ_SET, '1, 4'd8, 32'h8000_0000);
        send_item(REQ_LOOKUP, '1, 4'd15, '0);
        send_item(REQ_LOOKUP, '1, 4'd7, '0);
        // embedded zero bytes are content: "A\0\0" differs from "A" and "A\0"
        send_item(REQ_SET, 64'h0000_0041, 4'd3, '0);
        send_item(REQ_SET, 64'hFF00_0041, 4'd1, '1);
        send_item(REQ_LOOKUP, 64'h0000_0041, 4'd3, '0);
        send_item(REQ_LOOKUP, 64'h0000_0041, 4'd2, '0);
        // one-byte keys that share a home slot force a probe chain
        send_item(REQ_SET, 64'h01, 4'd1, 32'd1);
        send_item(REQ_SET, 64'h11, 4'd1, 32'd2);
        send_item(REQ_SET, 64'h21, 4'd1, 32'd3);
        // home slot at the top of the table: the second one wraps past slot 0 to slot 6
        send_item(REQ_SET, 64'h0F, 4'd1, 32'd15);
        send_item(REQ_SET, 64'h1F, 4'd1, 32'd31);
        send_item(REQ_LOOKUP, 64'h21, 4'd1, '0);
        send_item(REQ_LOOKUP, 64'h1F, 4'd1, '0);
        send_item(REQ_LOOKUP, 64'h31, 4'd1, '0);
        // stray bits above the length, different on store and on lookup
        send_item(REQ_SET, 64'hA5A5_5A5A_C3C3_3231, 4'd2, 32'd5);
        send_item(REQ_LOOKUP, 64'h5A5A_A5A5_3C3C_3231, 4'd2, '0);
        // update in place, then read back
        send_item(REQ_SET, 64'h11, 4'd1, 32'd22);
        send_item(REQ_LOOKUP, 64'h11, 4'd1, '0);
        send_item(REQ_SET, {$urandom, $urandom}, 4'd9, $urandom);
        idle_gap(0);

        // ---- random commands in four phases of sender idling ----
        run_phase(RANDOM_ITEMS / 4, 0);    // back to back
        run_phase(RANDOM_ITEMS / 4, 80);   // sender mostly idle
        run_phase(RANDOM_ITEMS / 4, 0);    // back to back again; strobes cannot stall
        run_phase(RANDOM_ITEMS - 3 * (RANDOM_ITEMS / 4), 32);

        i_start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        // watch for stray strobes after the last answer
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d lookups (%0d hits) and %0d sets (%0d updates, %0d dropped as full).",
                 sb.n_lookup, sb.n_lookup_hit, sb.n_set, sb.n_update, sb.n_full);
        $display("Table ended with %0d of %0d slots used; longest probe walk %0d slots.",
                 sb.occupancy, TABLE_SIZE, sb.longest_walk);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
